// File: src/ptc_pkg.sv
`timescale 1ns / 1ps

package ptc_pkg;

  typedef logic [5:0] kind_t;
  typedef logic [1:0] err_t;

  typedef struct packed {
    logic [7:0]  byte_req;
    logic        end_of_input;
    logic [31:0] byte_offset;
    logic [31:0] byte_line;
    logic [31:0] byte_col;
  } in_beat_t;

  typedef struct packed {
    kind_t       token_kind;
    err_t        error_code;
    logic [31:0] start_offset;
    logic [31:0] start_line;
    logic [31:0] start_col;
    logic        last;
  } out_beat_t;

  // Up to two results per byte, oldest in r0.
  typedef struct packed {
    logic [1:0] cnt;
    out_beat_t  r0;
    out_beat_t  r1;
  } push_t;

  typedef enum logic [4:0] {
    M_IDLE, M_PCT, M_AMP, M_PIPE, M_CARET, M_PLUS, M_MINUS, M_STAR, M_EQ,
    M_BANG, M_LT, M_LTLT, M_GT, M_GTGT, M_COLON, M_DOT, M_CR, M_SLASH,
    M_WS, M_LINE_FIRST, M_LINE, M_DOC, M_BLOCK, M_BLOCK_STAR
  } mode_t;

  localparam err_t ERR_NONE       = 2'd0;
  localparam err_t ERR_BAD_BYTE   = 2'd1;
  localparam err_t ERR_OPEN_BLOCK = 2'd2;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam kind_t K_SEMI = 6'd0, K_COMMA = 6'd1, K_LPAREN = 6'd2, K_RPAREN = 6'd3;
  localparam kind_t K_LBRACE = 6'd4, K_RBRACE = 6'd5, K_LBRACK = 6'd6, K_RBRACK = 6'd7;
  localparam kind_t K_AT = 6'd8, K_HASH = 6'd9, K_DOLLAR = 6'd10, K_QUEST = 6'd11;
  localparam kind_t K_TILDE = 6'd12, K_NEWLINE = 6'd13, K_PERCENT = 6'd14;
  localparam kind_t K_PERCENTEQ = 6'd15, K_ANDAND = 6'd16, K_ANDEQ = 6'd17, K_AND = 6'd18;
  localparam kind_t K_OROR = 6'd19, K_OREQ = 6'd20, K_OR = 6'd21, K_CARETEQ = 6'd22;
  localparam kind_t K_CARET = 6'd23, K_PLUSEQ = 6'd24, K_PLUSPLUS = 6'd25, K_PLUS = 6'd26;
  localparam kind_t K_ARROW = 6'd27, K_MINUSMINUS = 6'd28, K_MINUSEQ = 6'd29;
  localparam kind_t K_MINUS = 6'd30, K_STARSTAR = 6'd31, K_STAREQ = 6'd32, K_STAR = 6'd33;
  localparam kind_t K_DOC = 6'd34, K_LINECOM = 6'd35, K_BLOCKCOM = 6'd36;
  localparam kind_t K_SLASHEQ = 6'd37, K_SLASH = 6'd38, K_EQEQ = 6'd39, K_EQ = 6'd40;
  localparam kind_t K_NE = 6'd41, K_BANG = 6'd42, K_LE = 6'd43, K_SHLEQ = 6'd44;
  localparam kind_t K_SHL = 6'd45, K_LT = 6'd46, K_GE = 6'd47, K_SHREQ = 6'd48;
  localparam kind_t K_SHR = 6'd49, K_GT = 6'd50, K_COLCOL = 6'd51, K_COLEQ = 6'd52;
  localparam kind_t K_COLON = 6'd53, K_DOTDOT = 6'd54, K_DOT = 6'd55, K_WS = 6'd56;

  typedef struct packed {
    logic  emit;
    kind_t kind;
    err_t  err;
    mode_t mode;
  } step_t;

  // First byte of a token.
  function automatic step_t fresh_step(input logic [7:0] b);
    step_t s;
    s = '{emit: 1'b1, kind: K_SEMI, err: ERR_NONE, mode: M_IDLE};
    case (b)
      8'h3B: s.kind = K_SEMI;
      8'h2C: s.kind = K_COMMA;
      8'h28: s.kind = K_LPAREN;
      8'h29: s.kind = K_RPAREN;
      8'h7B: s.kind = K_LBRACE;
      8'h7D: s.kind = K_RBRACE;
      8'h5B: s.kind = K_LBRACK;
      8'h5D: s.kind = K_RBRACK;
      CH_AT: s.kind = K_AT;
      8'h23: s.kind = K_HASH;
      8'h24: s.kind = K_DOLLAR;
      8'h3F: s.kind = K_QUEST;
      8'h7E: s.kind = K_TILDE;
      CH_LF: s.kind = K_NEWLINE;
      8'h25: begin s.emit = 1'b0; s.mode = M_PCT; end
      8'h26: begin s.emit = 1'b0; s.mode = M_AMP; end
      8'h7C: begin s.emit = 1'b0; s.mode = M_PIPE; end
      8'h5E: begin s.emit = 1'b0; s.mode = M_CARET; end
      8'h2B: begin s.emit = 1'b0; s.mode = M_PLUS; end
      8'h2D: begin s.emit = 1'b0; s.mode = M_MINUS; end
      CH_STAR: begin s.emit = 1'b0; s.mode = M_STAR; end
      CH_SLASH: begin s.emit = 1'b0; s.mode = M_SLASH; end
      CH_EQ: begin s.emit = 1'b0; s.mode = M_EQ; end
      8'h21: begin s.emit = 1'b0; s.mode = M_BANG; end
      8'h3C: begin s.emit = 1'b0; s.mode = M_LT; end
      8'h3E: begin s.emit = 1'b0; s.mode = M_GT; end
      8'h3A: begin s.emit = 1'b0; s.mode = M_COLON; end
      8'h2E: begin s.emit = 1'b0; s.mode = M_DOT; end
      CH_CR: begin s.emit = 1'b0; s.mode = M_CR; end
      CH_SPACE: begin s.emit = 1'b0; s.mode = M_WS; end
      default: s.err = ERR_BAD_BYTE;
    endcase
    return s;
  endfunction

  // Pending token reported as is.
  function automatic step_t flush_step(input mode_t m);
    step_t s;
    s = '{emit: 1'b1, kind: K_SEMI, err: ERR_NONE, mode: M_IDLE};
    unique case (m)
      M_IDLE:       s.emit = 1'b0;
      M_PCT:        s.kind = K_PERCENT;
      M_AMP:        s.kind = K_AND;
      M_PIPE:       s.kind = K_OR;
      M_CARET:      s.kind = K_CARET;
      M_PLUS:       s.kind = K_PLUS;
      M_MINUS:      s.kind = K_MINUS;
      M_STAR:       s.kind = K_STAR;
      M_EQ:         s.kind = K_EQ;
      M_BANG:       s.kind = K_BANG;
      M_LT:         s.kind = K_LT;
      M_LTLT:       s.kind = K_SHL;
      M_GT:         s.kind = K_GT;
      M_GTGT:       s.kind = K_SHR;
      M_COLON:      s.kind = K_COLON;
      M_DOT:        s.kind = K_DOT;
      M_CR:         s.kind = K_NEWLINE;
      M_SLASH:      s.kind = K_SLASH;
      M_WS:         s.kind = K_WS;
      M_LINE_FIRST: s.kind = K_LINECOM;
      M_LINE:       s.kind = K_LINECOM;
      M_DOC:        s.kind = K_DOC;
      M_BLOCK:      s.err = ERR_OPEN_BLOCK;
      M_BLOCK_STAR: s.err = ERR_OPEN_BLOCK;
      default:      s.emit = 1'b0;
    endcase
    return s;
  endfunction

  // Byte after an operator prefix. emit: longer operator done.
  // go: stay in a longer prefix, mode holds the new prefix.
  typedef struct packed {
    logic  emit;
    logic  go;
    kind_t kind;
    mode_t mode;
  } op_t;

  function automatic op_t op_step(input mode_t m, input logic [7:0] b);
    op_t o;
    o = '{emit: 1'b0, go: 1'b0, kind: K_SEMI, mode: M_IDLE};
    case (m)
      M_PCT:   if (b == CH_EQ) begin o.emit = 1'b1; o.kind = K_PERCENTEQ; end
      M_AMP: begin
        if (b == 8'h26) begin o.emit = 1'b1; o.kind = K_ANDAND; end
        else if (b == CH_EQ) begin o.emit = 1'b1; o.kind = K_ANDEQ; end
      end
      M_PIPE: begin
        if (b == 8'h7C) begin o.emit = 1'b1; o.kind = K_OROR; end
        else if (b == CH_EQ) begin o.emit = 1'b1; o.kind = K_OREQ; end
      end
      M_CARET: if (b == CH_EQ) begin o.emit = 1'b1; o.kind = K_CARETEQ; end
      M_PLUS: begin
        if (b == CH_EQ) begin o.emit = 1'b1; o.kind = K_PLUSEQ; end
        else if (b == 8'h2B) begin o.emit = 1'b1; o.kind = K_PLUSPLUS; end
      end
      M_MINUS: begin
        if (b == 8'h3E) begin o.emit = 1'b1; o.kind = K_ARROW; end
        else if (b == 8'h2D) begin o.emit = 1'b1; o.kind = K_MINUSMINUS; end
        else if (b == CH_EQ) begin o.emit = 1'b1; o.kind = K_MINUSEQ; end
      end
      M_STAR: begin
        if (b == CH_STAR) begin o.emit = 1'b1; o.kind = K_STARSTAR; end
        else if (b == CH_EQ) begin o.emit = 1'b1; o.kind = K_STAREQ; end
      end
      M_EQ:    if (b == CH_EQ) begin o.emit = 1'b1; o.kind = K_EQEQ; end
      M_BANG:  if (b == CH_EQ) begin o.emit = 1'b1; o.kind = K_NE; end
      M_LT: begin
        if (b == 8'h3C) begin o.go = 1'b1; o.mode = M_LTLT; end
        else if (b == CH_EQ) begin o.emit = 1'b1; o.kind = K_LE; end
      end
      M_LTLT:  if (b == CH_EQ) begin o.emit = 1'b1; o.kind = K_SHLEQ; end
      M_GT: begin
        if (b == 8'h3E) begin o.go = 1'b1; o.mode = M_GTGT; end
        else if (b == CH_EQ) begin o.emit = 1'b1; o.kind = K_GE; end
      end
      M_GTGT:  if (b == CH_EQ) begin o.emit = 1'b1; o.kind = K_SHREQ; end
      M_COLON: begin
        if (b == 8'h3A) begin o.emit = 1'b1; o.kind = K_COLCOL; end
        else if (b == CH_EQ) begin o.emit = 1'b1; o.kind = K_COLEQ; end
      end
      M_DOT:   if (b == 8'h2E) begin o.emit = 1'b1; o.kind = K_DOTDOT; end
      M_CR:    if (b == CH_LF) begin o.emit = 1'b1; o.kind = K_NEWLINE; end
      M_SLASH: begin
        if (b == CH_SLASH) begin o.go = 1'b1; o.mode = M_LINE_FIRST; end
        else if (b == CH_STAR) begin o.go = 1'b1; o.mode = M_BLOCK; end
        else if (b == CH_EQ) begin o.emit = 1'b1; o.kind = K_SLASHEQ; end
      end
      default: o.emit = 1'b0;
    endcase
    return o;
  endfunction

endpackage

// File: src/punctuation_comment_tokenizer.sv
`timescale 1ns / 1ps

// Channel   Dir   Handshake             Beat
// in_       in    in_valid / in_stall   one source byte or end-of-input flush
// out_      out   out_valid / out_stall one token or error, last marks final
//
// One byte per cycle while in_stall is low. Each byte waits in the input register,
// where the scan step produces up to two results into a four-entry result queue;
// a result is visible the cycle after its byte is processed.
// The queue passes on one result per cycle while out_stall is low; a byte that
// yields two results needs two output beats, so the slower side sets the rate.
// in_stall rises while a byte waits in the input register and the queue has
// fewer than two free entries.
// Synchronous active-low reset: idle, no pending token, start position zero.

module punctuation_comment_tokenizer import ptc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  push_t push;
  logic  room;

  ptc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .room     (room),
    .push     (push)
  );

  ptc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: src/ptc_core.sv
`timescale 1ns / 1ps

module ptc_core import ptc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_beat_t in_data,
  input  logic     room,
  output push_t    push
);

  in_beat_t    in_r;
  logic        vld_r, vld_nxt;
  mode_t       mode_r, mode_nxt;
  logic [31:0] off_r, off_nxt;
  logic [31:0] line_r, line_nxt;
  logic [31:0] col_r, col_nxt;

  logic      proc, accept;
  logic      do_flush, do_fresh;
  logic      a_vld, b_vld;
  out_beat_t a_res, b_res;
  step_t     fl, fr;
  op_t       op;
  logic [7:0] b;

  assign proc     = vld_r & room;
  assign in_stall = vld_r & ~room;
  assign accept   = in_valid & ~in_stall;
  assign b        = in_r.byte_req;
  assign fl       = flush_step(mode_r);
  assign fr       = fresh_step(b);
  assign op       = op_step(mode_r, b);

  always_comb begin
    vld_nxt  = accept ? 1'b1 : (proc ? 1'b0 : vld_r);
    mode_nxt = mode_r;
    off_nxt  = off_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    do_flush = 1'b0;
    do_fresh = 1'b0;
    a_vld    = 1'b0;
    a_res    = '{token_kind: K_SEMI, error_code: ERR_NONE, start_offset: off_r,
                 start_line: line_r, start_col: col_r, last: 1'b0};
    if (in_r.end_of_input) begin
      do_flush = 1'b1;
      mode_nxt = M_IDLE;
    end else begin
      unique case (mode_r) inside
        M_IDLE: do_fresh = 1'b1;
        M_PCT, M_AMP, M_PIPE, M_CARET, M_PLUS, M_MINUS, M_STAR, M_EQ, M_BANG,
        M_LT, M_LTLT, M_GT, M_GTGT, M_COLON, M_DOT, M_CR, M_SLASH: begin
          if (op.go) begin
            mode_nxt = op.mode;
          end else if (op.emit) begin
            a_vld            = 1'b1;
            a_res.token_kind = op.kind;
            mode_nxt         = M_IDLE;
          end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        M_WS: begin
          if (b != CH_SPACE && b != CH_TAB) begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        M_LINE_FIRST, M_LINE, M_DOC: begin
          if (b == CH_LF || b == CH_VT || b == CH_FF || b == CH_CR) begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end else if (mode_r == M_LINE_FIRST) begin
            mode_nxt = (b == CH_AT) ? M_DOC : M_LINE;
          end
        end
        M_BLOCK: if (b == CH_STAR) mode_nxt = M_BLOCK_STAR;
        M_BLOCK_STAR: begin
          if (b == CH_SLASH) begin
            a_vld            = 1'b1;
            a_res.token_kind = K_BLOCKCOM;
            mode_nxt         = M_IDLE;
          end else if (b != CH_STAR) begin
            mode_nxt = M_BLOCK;
          end
        end
        default: do_fresh = 1'b1;
      endcase
    end
    if (do_flush) begin
      a_vld            = fl.emit;
      a_res.token_kind = fl.kind;
      a_res.error_code = fl.err;
      mode_nxt         = M_IDLE;
    end
    b_vld = do_fresh & fr.emit;
    b_res = '{token_kind: fr.kind, error_code: fr.err, start_offset: in_r.byte_offset,
              start_line: in_r.byte_line, start_col: in_r.byte_col, last: 1'b1};
    if (do_fresh) begin
      mode_nxt = fr.mode;
      off_nxt  = in_r.byte_offset;
      line_nxt = in_r.byte_line;
      col_nxt  = in_r.byte_col;
    end
    push.cnt     = proc ? ({1'b0, a_vld} + {1'b0, b_vld}) : 2'd0;
    push.r0      = a_vld ? a_res : b_res;
    push.r0.last = ~(a_vld & b_vld);
    push.r1      = b_res;
  end

  always_ff @(posedge clk) begin
    if (accept) in_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      mode_r <= M_IDLE;
      off_r  <= '0;
      line_r <= '0;
      col_r  <= '0;
    end else begin
      vld_r <= vld_nxt;
      if (proc) begin
        mode_r <= mode_nxt;
        off_r  <= off_nxt;
        line_r <= line_nxt;
        col_r  <= col_nxt;
      end
    end
  end

endmodule

// File: src/ptc_outq.sv
`timescale 1ns / 1ps

module ptc_outq import ptc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  out_beat_t  q_r [4];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = q_r[rd_r];
  assign pop       = out_valid & ~out_stall;
  assign room      = (cnt_r < 3'd3);

  always_comb begin
    wr_nxt  = wr_r + push.cnt;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push.cnt} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) q_r[wr_r] <= push.r0;
    if (push.cnt == 2'd2) q_r[wr_r + 2'd1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
